// ----- sv/brf_pkg.sv -----
// Package for the byte ring FIFO: sizes, command codes, queue entry and
// back-end state types. No dependencies.
`default_nettype none

package brf_pkg;

  localparam int DEPTH   = 16;
  localparam int AW      = $clog2(DEPTH);
  localparam int PW      = AW + 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int DATA_W  = 8;
  localparam int REQ_W   = 8;
  localparam int FIELD_W = 5;
  localparam int CMP_W   = (CW > REQ_W) ? CW : REQ_W;

  localparam int QDEPTH  = 2;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic              is_read;
    logic [DATA_W-1:0] wbyte;
    logic [AW-1:0]     addr;
    logic              accepted;
    logic [CW-1:0]     granted;
    logic [CW-1:0]     fill;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage

`default_nettype wire

// ----- sv/brf_queue.sv -----
// Short in-order queue of classified commands between front and back end.
// Depends on brf_pkg.
`default_nettype none

module brf_queue import brf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t entry_in,
  input  wire logic   pop,
  output entry_t      entry_out,
  output qstat_t      stat
);

  entry_t           slots [QDEPTH];
  logic [QAW-1:0]   head;
  logic [QAW-1:0]   tail;
  logic [QCW-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QAW'(1);
      end
      if (pop) begin
        head <= head + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= entry_in;
    end
  end

  assign entry_out  = slots[head];
  assign stat.full  = (count == QCW'(QDEPTH));
  assign stat.empty = (count == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    stat.full && !pop |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- sv/brf_front.sv -----
// Front end: accepts command beats, tracks the pointers, clamps read counts
// and pushes classified entries into the queue. Depends on brf_pkg.
`default_nettype none

module brf_front import brf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              cmd,
  input  wire logic [DATA_W-1:0] write_byte,
  input  wire logic [REQ_W-1:0]  req_count,
  input  wire qstat_t            qstat,
  output logic                   busy,
  output logic                   push,
  output entry_t                 entry
);

  logic [PW-1:0]    write_ptr;
  logic [PW-1:0]    read_ptr;
  logic [PW-1:0]    write_ptr_next;
  logic [PW-1:0]    read_ptr_next;
  logic [CW-1:0]    held;
  logic [CMP_W-1:0] req_w;
  logic [CMP_W-1:0] held_w;
  logic [CW-1:0]    granted;
  logic             room;

  assign busy   = qstat.full;
  assign push   = start && !busy;
  assign held   = CW'(write_ptr - read_ptr);
  assign room   = (held < CW'(DEPTH));
  assign req_w  = CMP_W'(req_count);
  assign held_w = CMP_W'(held);
  assign granted = (req_w < held_w) ? CW'(req_w) : held;

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    entry.is_read  = (cmd == CMD_READ);
    entry.wbyte    = write_byte;
    if (cmd == CMD_READ) begin
      entry.addr     = read_ptr[AW-1:0];
      entry.accepted = 1'b0;
      entry.granted  = granted;
      entry.fill     = held - granted;
      read_ptr_next  = read_ptr + PW'(granted);
    end else begin
      entry.addr     = write_ptr[AW-1:0];
      entry.accepted = room;
      entry.granted  = '0;
      entry.fill     = held + CW'(room);
      write_ptr_next = write_ptr + PW'(room);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else if (push) begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(DEPTH))
    else $error("pointer distance exceeds depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    push && cmd == CMD_WRITE && held == CW'(DEPTH) |=> $stable(write_ptr))
    else $error("write pointer moved on full store");

  a_grant_clamp: assert property (@(posedge clk) disable iff (rst)
    push && cmd == CMD_READ |-> entry.granted <= held)
    else $error("grant above bytes held");

endmodule

`default_nettype wire

// ----- sv/brf_back.sv -----
// Back end: pops classified entries, owns the byte store, writes bytes and
// streams granted bytes out one beat per cycle. Depends on brf_pkg.
`default_nettype none

module brf_back import brf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire entry_t             entry,
  input  wire qstat_t             qstat,
  output logic                    pop,
  output logic                    strobe,
  output logic [DATA_W-1:0]       read_byte,
  output logic                    byte_valid,
  output logic                    write_accepted,
  output logic [FIELD_W-1:0]      granted_count,
  output logic [FIELD_W-1:0]      fill_level,
  output logic                    last
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  back_state_t state;
  back_state_t state_next;
  entry_t      cur;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_inc;

  // issue-stage controls
  logic          iss_valid;
  logic          iss_bvalid;
  logic          iss_acc;
  logic [CW-1:0] iss_granted;
  logic [CW-1:0] iss_fill;
  logic          iss_last;
  logic [AW-1:0] rd_addr;
  logic          we;

  // output-stage registers
  logic          s_valid;
  logic          s_bvalid;
  logic          s_acc;
  logic [CW-1:0] s_granted;
  logic [CW-1:0] s_fill;
  logic          s_last;

  logic          multi;

  assign cnt_inc = cnt + CW'(1);
  assign multi   = entry.is_read && (entry.granted != '0) && (entry.granted != CW'(1));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!qstat.empty && multi) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        if (cnt_inc == cur.granted) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    iss_valid   = 1'b0;
    iss_bvalid  = 1'b0;
    iss_acc     = 1'b0;
    iss_granted = '0;
    iss_fill    = '0;
    iss_last    = 1'b0;
    rd_addr     = '0;
    we          = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop         = 1'b1;
          iss_valid   = 1'b1;
          iss_granted = entry.granted;
          iss_fill    = entry.fill;
          rd_addr     = entry.addr;
          if (entry.is_read && entry.granted != '0) begin
            iss_bvalid = 1'b1;
            iss_last   = (entry.granted == CW'(1));
          end else begin
            iss_last = 1'b1;
            iss_acc  = !entry.is_read && entry.accepted;
            we       = !entry.is_read && entry.accepted;
          end
        end
      end
      BK_READ: begin
        iss_valid   = 1'b1;
        iss_bvalid  = 1'b1;
        iss_granted = cur.granted;
        iss_fill    = cur.fill;
        iss_last    = (cnt_inc == cur.granted);
        rd_addr     = cur.addr + AW'(cnt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      s_valid <= 1'b0;
    end else begin
      state   <= state_next;
      s_valid <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= entry;
      cnt <= CW'(1);
    end else if (state == BK_READ) begin
      cnt <= cnt_inc;
    end
    s_bvalid  <= iss_bvalid;
    s_acc     <= iss_acc;
    s_granted <= iss_granted;
    s_fill    <= iss_fill;
    s_last    <= iss_last;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[entry.addr] <= entry.wbyte;
    end
    rdata <= mem[rd_addr];
  end

  assign strobe         = s_valid;
  assign read_byte      = s_bvalid ? rdata : '0;
  assign byte_valid     = s_bvalid;
  assign write_accepted = s_acc;
  assign granted_count  = FIELD_W'(s_granted);
  assign fill_level     = FIELD_W'(s_fill);
  assign last           = s_last;

  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_last |=> s_valid && s_bvalid)
    else $error("read burst broken before last beat");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_bvalid |-> s_last)
    else $error("non-data beat without last");

  a_data_has_grant: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_bvalid |-> s_granted != '0 && !s_acc)
    else $error("data beat without a grant");

endmodule

`default_nettype wire

// ----- sv/byte_ring_fifo.sv -----
// Byte ring FIFO, 16 entries. A command accepted at an edge passes through the queue
// and the back end's output registers to its first result beat; the result strobe is
// high one cycle per beat and the receiver cannot stall.
// The back end issues a write or empty read as a single beat and a read granting N bytes
// as N beats, one store read per cycle; busy rises when the 2-entry queue
// fills. Reset (synchronous) clears pointers, queue and control; the store is not cleared.
`default_nettype none

module byte_ring_fifo import brf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd,
  input  wire logic [DATA_W-1:0]  write_byte,
  input  wire logic [REQ_W-1:0]   req_count,
  output logic                    strobe,
  output logic [DATA_W-1:0]       read_byte,
  output logic                    byte_valid,
  output logic                    write_accepted,
  output logic [FIELD_W-1:0]      granted_count,
  output logic [FIELD_W-1:0]      fill_level,
  output logic                    last
);

  entry_t push_entry;
  entry_t head_entry;
  qstat_t qstat;
  logic   push;
  logic   pop;

  brf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .write_byte (write_byte),
    .req_count  (req_count),
    .qstat      (qstat),
    .busy       (busy),
    .push       (push),
    .entry      (push_entry)
  );

  brf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .pop       (pop),
    .entry_out (head_entry),
    .stat      (qstat)
  );

  brf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .entry          (head_entry),
    .qstat          (qstat),
    .pop            (pop),
    .strobe         (strobe),
    .read_byte      (read_byte),
    .byte_valid     (byte_valid),
    .write_accepted (write_accepted),
    .granted_count  (granted_count),
    .fill_level     (fill_level),
    .last           (last)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for byte_ring_fifo: queued command driver, strobe monitor
// and a ring-buffer predictor that forms every expected result beat.
// Depends on brf_pkg and the byte_ring_fifo RTL.
`timescale 1ns / 1ps

module testbench;
  import brf_pkg::*;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 24;
  localparam int CALM_TAIL     = 40;    // no idling while this few ops remain
  localparam int RANDOM_OPS    = 196;

  typedef struct {
    logic              op_cmd;
    logic [DATA_W-1:0] wbyte;
    logic [REQ_W-1:0]  req;
    bit                drain_first;  // hold off until every expected beat is seen
  } fifo_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]  rbyte;
    logic               valid;
    logic               accepted;
    logic [FIELD_W-1:0] granted;
    logic [FIELD_W-1:0] fill;
    logic               last;
  } fifo_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cmd = CMD_WRITE;
  logic [DATA_W-1:0] write_byte = '0;
  logic [REQ_W-1:0] req_count = '0;
  logic busy, strobe, byte_valid, write_accepted, last;
  logic [DATA_W-1:0] read_byte;
  logic [FIELD_W-1:0] granted_count, fill_level;

  fifo_op_t   pending_ops[$];
  fifo_beat_t expected_beats[$];

  // predictor state
  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [PW-1:0]     ring_wr = '0;
  logic [PW-1:0]     ring_rd = '0;

  int errors = 0;
  int gap_left = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  byte_ring_fifo DUT (
    .clk, .rst, .start, .busy, .cmd, .write_byte, .req_count,
    .strobe, .read_byte, .byte_valid, .write_accepted,
    .granted_count, .fill_level, .last
  );

  function automatic void add_op(logic op_cmd, logic [DATA_W-1:0] wbyte,
                                 logic [REQ_W-1:0] req, bit drain_first = 0);
    fifo_op_t op;
    op.op_cmd = op_cmd;
    op.wbyte = wbyte;
    op.req = req;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
  endfunction

  task automatic predict_ring_op(input logic op_cmd, input logic [DATA_W-1:0] wbyte,
                                 input logic [REQ_W-1:0] req);
    int held, grant;
    logic [PW-1:0] ptr_diff;
    fifo_beat_t b;
    // pointer distance wraps at the pointer width
    ptr_diff = ring_wr - ring_rd;
    held = int'(ptr_diff);
    b = '0;
    b.last = 1'b1;
    if (op_cmd == CMD_WRITE) begin
      if (held < DEPTH) begin
        ring_mem[ring_wr[AW-1:0]] = wbyte;
        ring_wr = ring_wr + 1'b1;
        b.accepted = 1'b1;
      end
      b.fill = FIELD_W'(ring_wr - ring_rd);
      expected_beats.push_back(b);
    end else begin
      grant = (int'(req) < held) ? int'(req) : held;
      b.fill = FIELD_W'(held - grant);
      if (grant == 0) begin
        expected_beats.push_back(b);
      end else begin
        for (int i = 0; i < grant; i++) begin
          b.rbyte = ring_mem[ring_rd[AW-1:0]];
          ring_rd = ring_rd + 1'b1;
          b.valid = 1'b1;
          b.granted = FIELD_W'(grant);
          b.last = (i == grant - 1);
          expected_beats.push_back(b);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // command driver
  always @(posedge clk) begin : driver
    logic go;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_ring_op(cmd, write_byte, req_count);
        pending_ops.delete(0);
        if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 8);
      end
      if (start && busy) begin
        go = 1'b1;  // keep offering the same beat
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        if (!pending_ops[0].drain_first || expected_beats.size() == 0)
          go = 1'b1;
      end
      start <= go;
      if (go) begin
        cmd <= pending_ops[0].op_cmd;
        write_byte <= pending_ops[0].wbyte;
        req_count <= pending_ops[0].req;
      end
    end
  end

  // result monitor; results cannot be stalled
  always @(posedge clk) begin : monitor
    fifo_beat_t want;
    if (!rst && strobe) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: read_byte %0d fill_level %0d last %0b",
                 $time, read_byte, fill_level, last);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("read_byte", want.rbyte, read_byte);
        check_field("byte_valid", want.valid, byte_valid);
        check_field("write_accepted", want.accepted, write_accepted);
        check_field("granted_count", want.granted, granted_count);
        check_field("fill_level", want.fill, fill_level);
        check_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int mode, mode_left, pick;
    logic [REQ_W-1:0] req;
    // directed: empty reads, fill past full, zero and oversized reads
    add_op(CMD_READ, 8'h00, 8'd0);
    add_op(CMD_READ, 8'hFF, 8'd255);
    for (int i = 0; i < DEPTH + 2; i++)
      add_op(CMD_WRITE, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'h55 :
             (i == 3) ? 8'hAA : 8'(i * 37 + 11), 8'(i));
    add_op(CMD_READ, 8'h3C, 8'd0);
    add_op(CMD_READ, 8'h00, 8'd255);
    add_op(CMD_WRITE, 8'h81, 8'd0);
    add_op(CMD_READ, 8'h00, 8'd1);

    mode = 0;
    mode_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);  // 0 mixed, 1 filling, 2 draining
        mode_left = $urandom_range(8, 30);
      end
      mode_left--;
      pick = $urandom_range(0, 99);
      if ((mode == 0 && pick < 50) || (mode == 1 && pick < 85) || (mode == 2 && pick < 20)) begin
        add_op(CMD_WRITE, 8'($urandom()), 8'($urandom()), n == 0 || n == 110);
      end else begin
        case ($urandom_range(0, 9))
          0:       req = 8'd0;
          7:       req = 8'($urandom_range(7, 17));
          8:       req = 8'($urandom_range(16, 255));
          9:       req = 8'($urandom());
          default: req = 8'($urandom_range(1, 6));
        endcase
        add_op(CMD_READ, 8'($urandom()), req, n == 0 || n == 110);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0) @(posedge clk);
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
